[rtl/vbi_pkg.sv]
// Shared types, constants and helpers of the vector beam integrator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vbi_pkg;

	// Integrator fixed point: rates carry INT_SHIFT+1 fraction bits
	localparam int INT_SHIFT = 16;
	// |rate| <= 256 * 2^(INT_SHIFT+1), plus sign
	localparam int RATE_W    = INT_SHIFT + 10;
	// rate times an 8-bit unsigned multiplier
	localparam int PROD_W    = RATE_W + 9;

	// |delta_x - offset| * 9 stays below 2^12
	localparam int MAG_W     = 12;
	localparam int QUOT_W    = 9;
	// floor(a / 5) == (a * RECIP) >> RECIP_SH for every a below 2^MAG_W
	localparam int RECIP_SH  = 16;
	localparam int RECIP_W   = 14;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + 4) / 5);

	// floor(r * 2^INT_SHIFT / 5) for the remainders of the divide by five
	localparam logic [INT_SHIFT:0] FRAC1 = (INT_SHIFT+1)'((1 << INT_SHIFT) / 5);
	localparam logic [INT_SHIFT:0] FRAC2 = (INT_SHIFT+1)'((2 << INT_SHIFT) / 5);
	localparam logic [INT_SHIFT:0] FRAC3 = (INT_SHIFT+1)'((3 << INT_SHIFT) / 5);
	localparam logic [INT_SHIFT:0] FRAC4 = (INT_SHIFT+1)'((4 << INT_SHIFT) / 5);

	localparam int ADDR_W = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_CENTER_X   = 2'd0;
	localparam logic [1:0] REG_CENTER_Y   = 2'd1;
	localparam logic [1:0] REG_BEAM_COLOR = 2'd2;

	// request kinds; the fourth code is ignored
	localparam logic [1:0] RT_ZERO = 2'd0;
	localparam logic [1:0] RT_DOT  = 2'd1;
	localparam logic [1:0] RT_LINE = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic signed [7:0] offset;
		logic [7:0]        scale;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
		logic [7:0]        pattern;
		logic [6:0]        brightness;
	} req_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [2:0]         color;
		logic [7:0]         intensity;
		logic               last;
	} pnt_t;

	typedef struct packed {
		logic [30:0] center_x;
		logic [30:0] center_y;
		logic [2:0]  beam_color;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZFLUSH,
		ST_ZPOINT,
		ST_DOT,
		ST_LFLUSH,
		ST_LDIV,
		ST_LRATE,
		ST_RAMP,
		ST_SMUL,
		ST_SADD
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DOT,
		OP_FLUSH,
		OP_ZERO,
		OP_DIV,
		OP_RATE,
		OP_RAMP,
		OP_MUL,
		OP_STRAIGHT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic emit;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic dot_pending;
		logic flush_cond;
		logic steps_zero;
		logic res;
		logic ramp_emit;
		logic ramp_end;
		logic ramp_more;
		logic emit_ok;
	} sts_t;

	function automatic logic [INT_SHIFT:0] frac_of(input logic [2:0] r);
		logic [INT_SHIFT:0] f;
		case (r)
			3'd1:    f = FRAC1;
			3'd2:    f = FRAC2;
			3'd3:    f = FRAC3;
			3'd4:    f = FRAC4;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

[rtl/vbi_regs.sv]
// APB-style configuration registers: beam centre and colour.
// Depends on vbi_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module vbi_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vbi_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output vbi_pkg::cfg_t                    cfg
);
	import vbi_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= '0;
			cfg_q.center_y   <= '0;
			cfg_q.beam_color <= 3'd1;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_CENTER_X:   cfg_q.center_x   <= pwdata[30:0];
				REG_CENTER_Y:   cfg_q.center_y   <= pwdata[30:0];
				REG_BEAM_COLOR: cfg_q.beam_color <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CENTER_X:   prdata = {1'b0, cfg_q.center_x};
			REG_CENTER_Y:   prdata = {1'b0, cfg_q.center_y};
			REG_BEAM_COLOR: prdata = {29'd0, cfg_q.beam_color};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/vbi_ctrl.sv]
// Sequencing state machine (uses vbi_pkg): walks each request through
// its steps, issuing one datapath command per cycle unless stalled.
`default_nettype none

module vbi_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_type,
	output logic               req_ready,
	input  vbi_pkg::sts_t      sts,
	output vbi_pkg::cmd_t      cmd
);
	import vbi_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   emits;
	logic   go;

	// does the current step put a point out, and may it proceed
	always_comb begin
		unique case (state_q)
			ST_ZFLUSH: emits = sts.dot_pending;
			ST_LFLUSH: emits = sts.dot_pending && sts.flush_cond;
			ST_RAMP:   emits = sts.ramp_emit;
			ST_ZPOINT,
			ST_SADD:   emits = 1'b1;
			default:   emits = 1'b0;
		endcase
		go = !emits || sts.emit_ok;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_type)
						RT_ZERO: state_d = ST_ZFLUSH;
						RT_DOT:  state_d = ST_DOT;
						RT_LINE: state_d = ST_LFLUSH;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ZFLUSH: if (go) state_d = ST_ZPOINT;
			ST_ZPOINT: if (go) state_d = ST_IDLE;
			ST_DOT:    state_d = ST_IDLE;
			ST_LFLUSH: if (go) state_d = ST_LDIV;
			ST_LDIV:   state_d = ST_LRATE;
			ST_LRATE: begin
				if (!sts.steps_zero)
					state_d = ST_RAMP;
				else if (sts.res)
					state_d = ST_SMUL;
				else
					state_d = ST_IDLE;
			end
			ST_RAMP: begin
				if (go && sts.ramp_end)
					state_d = sts.ramp_more ? ST_SMUL : ST_IDLE;
			end
			ST_SMUL:   state_d = ST_SADD;
			ST_SADD:   if (go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd.op    = OP_NONE;
		cmd.emit  = 1'b0;
		cmd.last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid)
					cmd.op = OP_LOAD;
			end
			ST_ZFLUSH: if (go) begin
				cmd.op   = OP_FLUSH;
				cmd.emit = emits;
			end
			ST_ZPOINT: if (go) begin
				cmd.op   = OP_ZERO;
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
			end
			ST_DOT:    cmd.op = OP_DOT;
			ST_LFLUSH: if (go) begin
				cmd.op   = OP_FLUSH;
				cmd.emit = emits;
				cmd.last = sts.steps_zero && !sts.res;
			end
			ST_LDIV:   cmd.op = OP_DIV;
			ST_LRATE:  cmd.op = OP_RATE;
			ST_RAMP: if (go) begin
				cmd.op   = OP_RAMP;
				cmd.emit = sts.ramp_emit;
				cmd.last = sts.ramp_end && !sts.ramp_more;
			end
			ST_SMUL:   cmd.op = OP_MUL;
			ST_SADD: if (go) begin
				cmd.op   = OP_STRAIGHT;
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

[rtl/vbi_dp.sv]
// Datapath: request register, integrators, pending dot, rate scaling,
// ramp counters, straight-segment multipliers and the point register.
// Depends on vbi_pkg; driven by commands from vbi_ctrl.
`default_nettype none

module vbi_dp (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  vbi_pkg::req_t  req_data,
	input  vbi_pkg::cfg_t  cfg,
	input  vbi_pkg::cmd_t  cmd,
	output vbi_pkg::sts_t  sts,
	output logic           pnt_valid,
	input  wire logic      pnt_ready,
	output vbi_pkg::pnt_t  pnt_data
);
	import vbi_pkg::*;

	req_t                     req_q;
	logic [31:0]              x_q;
	logic [31:0]              y_q;
	logic [31:0]              dot_x_q;
	logic [31:0]              dot_y_q;
	logic [7:0]               dot_int_q;
	logic                     pending_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic [QUOT_W-1:0]        quot_q;
	logic signed [RATE_W-1:0] xr_q;
	logic signed [RATE_W-1:0] yr_q;
	logic [7:0]               inten_q;
	logic [6:0]               steps_q;
	logic [2:0]               sh_q;
	logic signed [PROD_W-1:0] px_q;
	logic signed [PROD_W-1:0] py_q;
	pnt_t                     out_q;
	logic                     out_valid_q;

	logic signed [8:0]        dxo;
	logic signed [8:0]        dyo;
	logic [8:0]               dabs;
	logic [MAG_W-1:0]         mag_d;
	logic [MAG_W+RECIP_W-1:0] recip_prod;
	logic [MAG_W-1:0]         rem_full;
	logic [RATE_W-1:0]        rate_mag;
	logic signed [RATE_W-1:0] xr_d;
	logic signed [RATE_W-1:0] yr_d;
	logic [8:0]               bright3;
	logic signed [31:0]       off32;
	logic signed [8:0]        mult;
	logic signed [PROD_W-1:0] px_half;
	logic signed [PROD_W-1:0] py_half;
	logic [31:0]              nx;
	logic [31:0]              ny;
	logic [7:0]               em_int;
	logic                     emit_ok;

	// rate scaling: x rate = trunc((dx - offset) * 2^(S+1) * 9 / 10)
	always_comb begin
		dxo        = 9'(req_q.delta_x) - 9'(req_q.offset);
		dyo        = 9'(req_q.delta_y) + 9'(req_q.offset);
		dabs       = dxo[8] ? 9'(-dxo) : 9'(dxo);
		mag_d      = MAG_W'({dabs, 3'b000}) + MAG_W'(dabs);
		recip_prod = mag_q * RECIP;
		rem_full   = mag_q - ((MAG_W'(quot_q) << 2) + MAG_W'(quot_q));
		rate_mag   = (RATE_W'(quot_q) << INT_SHIFT) + RATE_W'(frac_of(rem_full[2:0]));
		xr_d       = neg_q ? -$signed(rate_mag) : $signed(rate_mag);
		yr_d       = RATE_W'(dyo) <<< (INT_SHIFT + 1);
		bright3    = {1'b0, req_q.brightness, 1'b0} + {2'b00, req_q.brightness};
		off32      = 32'(req_q.offset) <<< INT_SHIFT;
		mult       = $signed({1'b0, steps_q, req_q.scale[0]});
		px_half    = px_q >>> 1;
		py_half    = py_q >>> 1;
	end

	// next integrator values and intensity of the point going out
	always_comb begin
		nx     = x_q;
		ny     = y_q;
		em_int = '0;
		case (cmd.op)
			OP_FLUSH: begin
				nx     = dot_x_q;
				ny     = dot_y_q;
				em_int = dot_int_q;
			end
			OP_ZERO: begin
				nx = {1'b0, cfg.center_x} - off32;
				ny = {1'b0, cfg.center_y} + off32;
			end
			OP_RAMP: begin
				nx     = x_q + 32'(xr_q);
				ny     = y_q - 32'(yr_q);
				em_int = inten_q & {8{req_q.pattern[sh_q]}};
			end
			OP_STRAIGHT: begin
				nx     = x_q + 32'(px_half);
				ny     = y_q - 32'(py_half);
				em_int = inten_q & {8{req_q.pattern[0]}};
			end
			default: ;
		endcase
	end

	assign emit_ok = !out_valid_q || pnt_ready;

	always_comb begin
		sts.dot_pending = pending_q;
		sts.flush_cond  = !req_q.pattern[7] || (req_q.brightness == 7'd0);
		sts.steps_zero  = (req_q.scale[7:1] == 7'd0);
		sts.res         = req_q.scale[0];
		sts.ramp_end    = (sh_q == 3'd1) || (steps_q == 7'd1);
		sts.ramp_emit   = sts.ramp_end
			|| (req_q.pattern[sh_q] != req_q.pattern[sh_q - 3'd1]);
		sts.ramp_more   = (steps_q != 7'd1) || req_q.scale[0];
		sts.emit_ok     = emit_ok;
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			dot_x_q   <= '0;
			dot_y_q   <= '0;
			dot_int_q <= '0;
			pending_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_DOT: begin
					dot_x_q   <= x_q;
					dot_y_q   <= y_q;
					dot_int_q <= {req_q.brightness, 1'b0};
					pending_q <= 1'b1;
				end
				OP_FLUSH: pending_q <= 1'b0;
				OP_ZERO, OP_RAMP, OP_STRAIGHT: begin
					x_q <= nx;
					y_q <= ny;
				end
				default: ;
			endcase
		end
	end

	// working registers of a request
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: req_q <= req_data;
			OP_FLUSH: begin
				mag_q <= mag_d;
				neg_q <= dxo[8];
			end
			OP_DIV:  quot_q <= recip_prod[RECIP_SH +: QUOT_W];
			OP_RATE: begin
				xr_q    <= xr_d;
				yr_q    <= yr_d;
				inten_q <= bright3[8:1];
				steps_q <= req_q.scale[7:1];
				sh_q    <= 3'd7;
			end
			OP_RAMP: begin
				steps_q <= steps_q - 7'd1;
				sh_q    <= sh_q - 3'd1;
			end
			OP_MUL: begin
				px_q <= xr_q * mult;
				py_q <= yr_q * mult;
			end
			default: ;
		endcase
	end

	// point register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (pnt_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.point_x   <= nx;
			out_q.point_y   <= ny;
			out_q.color     <= cfg.beam_color;
			out_q.intensity <= em_int;
			out_q.last      <= cmd.last;
		end
	end

	assign pnt_valid = out_valid_q;
	assign pnt_data  = out_q;

endmodule

`default_nettype wire

[rtl/vector_beam_integrator.sv]
// Top level of the vector beam integrator: APB registers, sequencer and datapath.
// Depends on vbi_pkg, vbi_regs, vbi_ctrl and vbi_dp.
//
//   port group   direction  handshake              payload
//   req_*        in         req_valid / req_ready  req_data (vbi_pkg::req_t)
//   pnt_*        out        pnt_valid / pnt_ready  pnt_data (vbi_pkg::pnt_t)
//   p*           in/out     psel, penable, pready  paddr, pwdata, prdata
//
// One request at a time. A dot is held pending; a zero flushes it and emits the
// centre point; a line flushes it, may ramp the shared integrator adders one
// pattern bit per cycle unless stalled, and may end in a straight segment.
// Each point goes through one output register; a step that emits waits while
// that register is full and not being taken, so pnt_ready stalls the sequencer.
// Reset at once clears integrators, pending dot and centres, sets colour 1 and idles control.
`default_nettype none

module vector_beam_integrator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  vbi_pkg::req_t                   req_data,
	output logic                            pnt_valid,
	input  wire logic                       pnt_ready,
	output vbi_pkg::pnt_t                   pnt_data,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vbi_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import vbi_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	vbi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vbi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.pnt_valid (pnt_valid),
		.pnt_ready (pnt_ready),
		.pnt_data  (pnt_data)
	);

endmodule

`default_nettype wire

[rtl/vbi_checker.sv]
// Port-level checks of the vector beam integrator, bound to the top level.
// Depends on vbi_pkg and vector_beam_integrator.
`default_nettype none

module vbi_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input vbi_pkg::req_t                   req_data,
	input wire logic                       pnt_valid,
	input wire logic                       pnt_ready,
	input vbi_pkg::pnt_t                   pnt_data,
	input wire logic                       psel,
	input wire logic                       penable,
	input wire logic                       pwrite,
	input wire logic [vbi_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0]                pwdata,
	input wire logic [31:0]                prdata,
	input wire logic                       pready
);
	import vbi_pkg::*;

	// a point waiting to be taken holds still
	a_pnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && !pnt_ready |=> pnt_valid && $stable(pnt_data))
		else $error("point changed while stalled");

	// a meaningful request that is taken leaves the block busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.req_type == RT_ZERO
			|| req_data.req_type == RT_DOT || req_data.req_type == RT_LINE)
		|=> !req_ready)
		else $error("request taken while a request was in progress");

	// a new point only appears out of a request in progress
	a_point_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pnt_valid) |-> !$past(req_ready))
		else $error("point appeared while idle");

	// the colour register reads back three bits only
	a_color_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[3:2] == REG_BEAM_COLOR) |-> (prdata[31:3] == 29'd0))
		else $error("colour register read back stray bits");

endmodule

bind vector_beam_integrator vbi_checker u_vbi_checker (.*);

`default_nettype wire
